>>> hw/rtl/mlprq_pkg.sv
package mlprq_pkg;

	// Fixed field widths of the transfer payloads
	localparam int unsigned ID_W     = 6;
	localparam int unsigned PRIO_W   = 4;
	localparam int unsigned RUN_W    = 32;
	localparam int unsigned STATUS_W = 2;

	// Low run-count bits that must be zero for aging to apply (period of 64)
	localparam int unsigned AGE_SHIFT = 6;

	// Largest number of ids the id field can address
	localparam int unsigned ID_SPACE = 64;

	// Command codes
	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd2;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic ld_in;
		logic calc_prod;
		logic find;
		logic calc_level;
		logic enq_write;
		logic deq_write;
		logic load_out;
	} ctrl_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic is_deq;
		logic found;
	} ctrl_sts_t;

endpackage

>>> hw/rtl/multilevel_priority_ready_queue_top.sv
// Channel | Direction | Handshake           | Payload
// --------+-----------+---------------------+-------------------------------------------
// in      | input     | in_valid / in_stall | cmd, task_id, base_priority, run_count
// out     | output    | out_valid/out_stall | status, out_task_id, out_level
//
// One command is in work at a time. Enqueue: start, level, read, write states; dequeue:
// start, read, link, write; empty dequeue: start, read. The steps are set by the
// two-step aging remainder and the registered reads of the head, tail and link memories.
// The finished result sits in an output register, so a new command may be taken while
// it waits; a full output register and out_stall hold the next result back.
// Reset clears the level and queued flags at once; the memories need no clearing.
module multilevel_priority_ready_queue_top
	import mlprq_pkg::*;
#(
	parameter int unsigned NUM_LEVELS = 16,
	parameter int unsigned NUM_TASKS  = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                cmd,
	input  logic [ID_W-1:0]     task_id,
	input  logic [PRIO_W-1:0]   base_priority,
	input  logic [RUN_W-1:0]    run_count,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [ID_W-1:0]     out_task_id,
	output logic [PRIO_W-1:0]   out_level
);

	ctrl_cmd_t ctl_cmd;
	ctrl_sts_t ctl_sts;

	// Sequencer
	mlprq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (ctl_sts),
		.cmd       (ctl_cmd)
	);

	// Queue storage and level arithmetic
	mlprq_dp #(
		.NUM_LEVELS (NUM_LEVELS),
		.NUM_TASKS  (NUM_TASKS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (ctl_cmd),
		.sts              (ctl_sts),
		.in_cmd           (cmd),
		.in_task_id       (task_id),
		.in_base_priority (base_priority),
		.in_run_count     (run_count),
		.res_status       (status),
		.res_task_id      (out_task_id),
		.res_level        (out_level)
	);

endmodule

>>> hw/rtl/mlprq_ram.sv
module mlprq_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port; a read returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hw/rtl/mlprq_ctrl.sv
module mlprq_ctrl
	import mlprq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	input  ctrl_sts_t sts,
	output ctrl_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_LEVEL = 3'd2;
	localparam logic [2:0] ST_ERD   = 3'd3;
	localparam logic [2:0] ST_EWR   = 3'd4;
	localparam logic [2:0] ST_DRD   = 3'd5;
	localparam logic [2:0] ST_DLINK = 3'd6;
	localparam logic [2:0] ST_DWR   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       done_q;
	logic       done_d;
	logic       out_valid_q;

	assign in_stall  = (state_q != ST_IDLE) || done_q;
	assign out_valid = out_valid_q;

	// Next-state and command decode
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		done_d  = done_q;
		if (done_q) begin
			// Result is ready; hand it to the output register once that is free.
			if (!out_valid_q || !out_stall) begin
				cmd.load_out = 1'b1;
				done_d       = 1'b0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd.ld_in = 1'b1;
						state_d   = ST_START;
					end
				end
				ST_START: begin
					cmd.calc_prod = 1'b1;
					if (sts.is_deq) begin
						cmd.find = 1'b1;
						state_d  = ST_DRD;
					end else begin
						state_d = ST_LEVEL;
					end
				end
				ST_LEVEL: begin
					cmd.calc_level = 1'b1;
					state_d        = ST_ERD;
				end
				ST_ERD: begin
					state_d = ST_EWR;
				end
				ST_EWR: begin
					cmd.enq_write = 1'b1;
					state_d       = ST_IDLE;
					done_d        = 1'b1;
				end
				ST_DRD: begin
					if (sts.found) begin
						state_d = ST_DLINK;
					end else begin
						state_d = ST_IDLE;
						done_d  = 1'b1;
					end
				end
				ST_DLINK: begin
					state_d = ST_DWR;
				end
				ST_DWR: begin
					cmd.deq_write = 1'b1;
					state_d       = ST_IDLE;
					done_d        = 1'b1;
				end
				default: begin
					state_d = ST_IDLE;
				end
			endcase
		end
	end

	// State and output-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> hw/rtl/mlprq_dp.sv
module mlprq_dp
	import mlprq_pkg::*;
#(
	parameter int unsigned NUM_LEVELS = 16,
	parameter int unsigned NUM_TASKS  = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctrl_cmd_t           cmd,
	output ctrl_sts_t           sts,
	input  logic                in_cmd,
	input  logic [ID_W-1:0]     in_task_id,
	input  logic [PRIO_W-1:0]   in_base_priority,
	input  logic [RUN_W-1:0]    in_run_count,
	output logic [STATUS_W-1:0] res_status,
	output logic [ID_W-1:0]     res_task_id,
	output logic [PRIO_W-1:0]   res_level
);

	// Only ids the id field can carry are ever stored.
	localparam int unsigned ID_SLOTS = (NUM_TASKS < ID_SPACE) ? NUM_TASKS : ID_SPACE;
	localparam int unsigned IW       = $clog2(ID_SLOTS);
	localparam int unsigned LW       = $clog2(NUM_LEVELS);
	localparam int unsigned SW       = ((LW > PRIO_W) ? LW : PRIO_W) + 1;
	localparam int unsigned XW       = RUN_W - AGE_SHIFT;
	localparam int unsigned PW       = XW + RUN_W;
	localparam int unsigned QW       = XW + 7;

	// Reciprocal of the level count; the quotient estimate is low by at most one.
	localparam longint unsigned RECIP_L = (64'd1 << RUN_W) / NUM_LEVELS;
	localparam logic [RUN_W-1:0] RECIP  = RECIP_L[RUN_W-1:0];
	localparam logic [QW-1:0] LVL_CNT_Q = QW'(NUM_LEVELS);
	localparam logic [LW:0]   LVL_CNT   = (LW+1)'(NUM_LEVELS);
	localparam logic [SW-1:0] LVL_MAX   = SW'(NUM_LEVELS - 1);
	localparam logic [10:0]   TASK_LIM  = 11'(NUM_TASKS);

	// Captured transfer
	logic              cmd_q;
	logic [ID_W-1:0]   id_q;
	logic [PRIO_W-1:0] base_q;
	logic [RUN_W-1:0]  run_q;

	// Working registers
	logic [PW-1:0]       prod_q;
	logic [LW-1:0]       level_q;
	logic                found_q;
	logic                reject_q;
	logic [IW-1:0]       pop_id_q;
	logic [NUM_LEVELS-1:0] nonempty_q;
	logic [ID_SLOTS-1:0] queued_q;

	// Memory ports
	logic          head_we;
	logic [IW-1:0] head_wdata;
	logic [IW-1:0] head_rdata;
	logic          tail_we;
	logic [IW-1:0] tail_rdata;
	logic          link_we;
	logic [IW-1:0] link_rdata;

	// Combinational helpers
	logic [LW-1:0]   ffs_level;
	logic            any_nonempty;
	logic [XW-1:0]   q_est;
	logic [QW-1:0]   q_mul;
	logic [QW-1:0]   r_wide;
	logic [LW:0]     r_est;
	logic [LW:0]     r_fix;
	logic [SW-1:0]   lvl_sum;
	logic [SW-1:0]   lvl_sat;
	logic            aged;
	logic            id_bad;
	logic [SW-1:0]   out_lvl_ext;
	logic            enq_ok;

	assign sts.is_deq = (cmd_q == CMD_DEQ);
	assign sts.found  = found_q;

	// Lowest-numbered non-empty level
	always_comb begin
		ffs_level    = '0;
		any_nonempty = 1'b0;
		for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
			if (nonempty_q[l]) begin
				ffs_level    = LW'(l);
				any_nonempty = 1'b1;
			end
		end
	end

	// Aged level: base priority plus, when aging applies, the remainder of (runs / 64) by the level count, then saturate
	always_comb begin
		q_est   = prod_q[PW-1:RUN_W];
		q_mul   = {7'd0, q_est} * LVL_CNT_Q;
		r_wide  = {7'd0, run_q[RUN_W-1:AGE_SHIFT]} - q_mul;
		r_est   = r_wide[LW:0];
		r_fix   = (r_est >= LVL_CNT) ? (r_est - LVL_CNT) : r_est;
		aged    = (run_q[AGE_SHIFT-1:0] == '0);
		lvl_sum = SW'(base_q) + (aged ? SW'(r_fix) : '0);
		lvl_sat = (lvl_sum > LVL_MAX) ? LVL_MAX : lvl_sum;
	end

	// Ids beyond the task count are refused like ids already queued.
	assign id_bad = ({5'd0, id_q} >= TASK_LIM);
	assign enq_ok = cmd.enq_write && !reject_q;

	// Memory write decode
	always_comb begin
		head_we    = 1'b0;
		head_wdata = id_q[IW-1:0];
		if (enq_ok && !nonempty_q[level_q]) begin
			head_we = 1'b1;
		end else if (cmd.deq_write && (head_rdata != tail_rdata)) begin
			head_we    = 1'b1;
			head_wdata = link_rdata;
		end
	end
	assign tail_we = enq_ok;
	assign link_we = enq_ok && nonempty_q[level_q];

	mlprq_ram #(.WIDTH(IW), .DEPTH(NUM_LEVELS)) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (level_q),
		.wdata (head_wdata),
		.raddr (level_q),
		.rdata (head_rdata)
	);

	mlprq_ram #(.WIDTH(IW), .DEPTH(NUM_LEVELS)) u_tail_ram (
		.clk   (clk),
		.we    (tail_we),
		.waddr (level_q),
		.wdata (id_q[IW-1:0]),
		.raddr (level_q),
		.rdata (tail_rdata)
	);

	mlprq_ram #(.WIDTH(IW), .DEPTH(ID_SLOTS)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (tail_rdata),
		.wdata (id_q[IW-1:0]),
		.raddr (head_rdata),
		.rdata (link_rdata)
	);

	// Payload and working registers
	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			cmd_q  <= in_cmd;
			id_q   <= in_task_id;
			base_q <= in_base_priority;
			run_q  <= in_run_count;
		end
		if (cmd.calc_prod) begin
			prod_q <= {{RUN_W{1'b0}}, run_q[RUN_W-1:AGE_SHIFT]} * {{XW{1'b0}}, RECIP};
		end
		if (cmd.find) begin
			level_q <= ffs_level;
			found_q <= any_nonempty;
		end
		if (cmd.calc_level) begin
			level_q  <= lvl_sat[LW-1:0];
			reject_q <= id_bad || queued_q[id_q[IW-1:0]];
		end
		if (cmd.deq_write) begin
			pop_id_q <= head_rdata;
		end
	end

	// Occupancy flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonempty_q <= '0;
			queued_q   <= '0;
		end else begin
			if (enq_ok) begin
				nonempty_q[level_q]      <= 1'b1;
				queued_q[id_q[IW-1:0]]   <= 1'b1;
			end
			if (cmd.deq_write) begin
				if (head_rdata == tail_rdata) begin
					nonempty_q[level_q] <= 1'b0;
				end
				queued_q[head_rdata] <= 1'b0;
			end
		end
	end

	// Output register, loaded once the result is complete
	assign out_lvl_ext = SW'(level_q);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (cmd_q == CMD_DEQ) begin
				if (found_q) begin
					res_status  <= STATUS_OK;
					res_task_id <= ID_W'(pop_id_q);
					res_level   <= out_lvl_ext[PRIO_W-1:0];
				end else begin
					res_status  <= STATUS_EMPTY;
					res_task_id <= '0;
					res_level   <= '0;
				end
			end else begin
				res_status  <= reject_q ? STATUS_REJECT : STATUS_OK;
				res_task_id <= '0;
				res_level   <= out_lvl_ext[PRIO_W-1:0];
			end
		end
	end

endmodule
